### rtl/core/alist_pkg.sv
`default_nettype none
package alist_pkg;

    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOCATE = 2'd2,
        OP_GET    = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

endpackage
`default_nettype wire

### rtl/core/array_list_engine_top.sv
// Ordered list engine: up to DEPTH signed 32-bit elements kept in one
// single-port-write, registered-read memory, plus an element count.
// Input channel (s_axis): tuser carries the opcode (insert, delete, locate,
// get), tdata the 1-based position and the value. Output channel (m_axis):
// tuser carries the status, tdata the element, the found position, the
// count after the operation and the empty flag.
// One item is worked at a time. The memory port moves one word a cycle:
//   insert at p <= n with n stored: words n down to p each move one slot up,
//   then the value is written at p
//   insert at the tail (p = n + 1): the value is written with no shift
//   delete at p: word p is read out, then words p + 1 up to n move one slot down
//   locate: words are compared from position 1 until a match or the tail
//   get: word p is read; refused items go straight to the output register
// The longest items are those that shift or scan through the whole memory.
// Reset clears the count and the output register; memory contents are not
// cleared and never read before written. When the receiver stalls, one result
// waits in the output register while the next item is taken and worked; that
// item then holds until the register is taken.
`default_nettype none
module array_list_engine_top
    import alist_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [6:0] position, [38:7] value, [39] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] opcode
    input  wire logic [OP_W-1:0]        i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [31:0] element, [38:32] found_position, [45:39] list_count,
    // [46] is_empty, [47] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // [1:0] status
    output logic [ST_W-1:0]             o_m_axis_tuser
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    alist_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    alist_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

endmodule
`default_nettype wire

### rtl/core/alist_mem.sv
`default_nettype none
module alist_mem
    import alist_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [VAL_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/core/alist_seq.sv
`default_nettype none
module alist_seq
    import alist_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic [OP_W-1:0]        i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic [ST_W-1:0]             o_m_axis_tuser,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [VAL_W-1:0]            o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  wire logic [VAL_W-1:0]       i_mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_UP, S_UP_LAST, S_INS_WR, S_DN, S_DN_LAST,
        S_SCAN, S_SCAN_LAST, S_GET, S_GET_W, S_FIN
    } t_state;

    // what to do with the word coming back from the memory this cycle
    typedef enum logic [1:0] {P_NONE, P_WR, P_CAP, P_CMP} t_pend;

    t_state           r_state;
    t_pend            r_pend;
    logic [CW-1:0]    r_cnt;
    logic [PW-1:0]    r_idx;
    logic [PW-1:0]    r_pw;
    logic [PW-1:0]    r_pos;
    logic [VAL_W-1:0] r_val;
    t_status          r_status;
    logic [VAL_W-1:0] r_elem;
    logic [POS_W-1:0] r_found;
    logic             r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic [ST_W-1:0]  r_ouser;

    t_opcode          in_op;
    logic [PW-1:0]    in_pos;
    logic [PW-1:0]    cnt_w;
    logic             hit;

    assign in_op  = t_opcode'(i_s_axis_tuser);
    assign in_pos = PW'(i_s_axis_tdata[POS_W-1:0]);
    assign cnt_w  = PW'(r_cnt);
    assign hit    = (r_pend == P_CMP) && (i_mem_rdata == r_val);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    always_comb begin
        o_mem_re    = (r_state == S_UP) || (r_state == S_DN) ||
                      (r_state == S_SCAN) || (r_state == S_GET);
        o_mem_raddr = r_idx[AW-1:0];
        if (r_state == S_INS_WR) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = AW'(r_pos - PW'(1));
            o_mem_wdata = r_val;
        end else begin
            o_mem_we    = (r_pend == P_WR);
            o_mem_waddr = r_pw[AW-1:0];
            o_mem_wdata = i_mem_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= P_NONE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= P_NONE;
            if (r_pend == P_CAP) begin
                r_elem <= i_mem_rdata;
            end
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_pos    <= in_pos;
                        r_val    <= i_s_axis_tdata[POS_W +: VAL_W];
                        r_status <= ST_OK;
                        r_elem   <= '0;
                        r_found  <= '0;
                        r_state  <= S_FIN;
                        case (in_op)
                            OP_INSERT: begin
                                if (in_pos == '0 || in_pos > cnt_w + PW'(1)) begin
                                    r_status <= ST_RANGE;
                                end else if (cnt_w == PW'(DEPTH)) begin
                                    r_status <= ST_FULL;
                                end else if (in_pos == cnt_w + PW'(1)) begin
                                    r_state <= S_INS_WR;
                                end else begin
                                    r_idx   <= cnt_w - PW'(1);
                                    r_state <= S_UP;
                                end
                            end
                            OP_DELETE: begin
                                if (in_pos == '0 || in_pos > cnt_w) begin
                                    r_status <= ST_RANGE;
                                end else begin
                                    r_idx   <= in_pos - PW'(1);
                                    r_state <= S_DN;
                                end
                            end
                            OP_LOCATE: begin
                                if (cnt_w == '0) begin
                                    r_status <= ST_MISSING;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                if (in_pos == '0 || in_pos > cnt_w) begin
                                    r_status <= ST_RANGE;
                                end else begin
                                    r_idx   <= in_pos - PW'(1);
                                    r_state <= S_GET;
                                end
                            end
                        endcase
                    end
                end
                // walk down from the tail, each word moves one slot up
                S_UP: begin
                    r_pend <= P_WR;
                    r_pw   <= r_idx + PW'(1);
                    if (r_idx == r_pos - PW'(1)) begin
                        r_state <= S_UP_LAST;
                    end else begin
                        r_idx <= r_idx - PW'(1);
                    end
                end
                S_UP_LAST: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_FIN;
                end
                // walk up from the hole; the first word read is the deleted one
                S_DN: begin
                    r_pend <= (r_idx == r_pos - PW'(1)) ? P_CAP : P_WR;
                    r_pw   <= r_idx - PW'(1);
                    if (r_idx == cnt_w - PW'(1)) begin
                        r_state <= S_DN_LAST;
                    end else begin
                        r_idx <= r_idx + PW'(1);
                    end
                end
                S_DN_LAST: begin
                    r_cnt   <= r_cnt - CW'(1);
                    r_state <= S_FIN;
                end
                S_SCAN: begin
                    if (hit) begin
                        r_found <= POS_W'(r_pw + PW'(1));
                        r_state <= S_FIN;
                    end else begin
                        r_pend <= P_CMP;
                        r_pw   <= r_idx;
                        if (r_idx == cnt_w - PW'(1)) begin
                            r_state <= S_SCAN_LAST;
                        end else begin
                            r_idx <= r_idx + PW'(1);
                        end
                    end
                end
                S_SCAN_LAST: begin
                    if (hit) begin
                        r_found <= POS_W'(r_pw + PW'(1));
                    end else begin
                        r_status <= ST_MISSING;
                    end
                    r_state <= S_FIN;
                end
                S_GET: begin
                    r_pend  <= P_CAP;
                    r_state <= S_GET_W;
                end
                S_GET_W: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ouser  <= r_status;
                        r_odata  <= {1'b0, (r_cnt == '0), POS_W'(cnt_w), r_found, r_elem};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
